>>> rtl/core/json_string_unescaper_macros.svh
// Assertion macros shared by the JSON string unescaper RTL.
// Each macro samples on clk and is disabled while rst_n is low.
// No dependencies; included by files that carry assertions.
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// Same-cycle implication.
`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/jsu_pkg.sv
// Types and constants for the JSON string unescaper.
// No dependencies; used by the decoder, result buffer and top level.
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
    localparam logic [2:0] ERR_END_ESC    = 3'd2;
    localparam logic [2:0] ERR_SHORT_U    = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd5;
    localparam logic [2:0] ERR_UNTERM     = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] ESC_B    = 8'h62;
    localparam logic [7:0] ESC_F    = 8'h66;
    localparam logic [7:0] ESC_N    = 8'h6E;
    localparam logic [7:0] ESC_R    = 8'h72;
    localparam logic [7:0] ESC_T    = 8'h74;
    localparam logic [7:0] ESC_U    = 8'h75;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] CP_2BYTE   = 16'h0080;
    localparam logic [15:0] CP_3BYTE   = 16'h0800;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic [2:0] error_code;
        logic       last_of_run;
    } out_item_t;

    // Up to three results caused by one input byte.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      kind;
        logic [2:0]      err;
        logic [1:0]      cnt;
    } bundle_t;

endpackage

>>> rtl/core/jsu_chan_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// Payload type comes from jsu_pkg at the instantiation site.
interface jsu_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/jsu_decoder.sv
// Escape decoder: phase/hex state and the result bundle for one text byte.
// Depends on jsu_pkg.
module jsu_decoder
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       text_end,
    output bundle_t    bundle
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] cp_reg, cp_next;

    logic        is_hex;
    logic [3:0]  hex_val;
    logic [15:0] cp_new;

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (in_byte inside {[8'h30:8'h39]})
        begin
            hex_val = in_byte[3:0];
        end
        else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            hex_val = in_byte[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign cp_new = {cp_reg[11:0], hex_val};

    always_comb
    begin
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        bundle       = '0;
        bundle.kind  = KIND_BYTE;
        bundle.err   = ERR_NONE;

        case (phase_reg)
            PH_IDLE:
            begin
                if (text_end)
                begin
                    bundle.kind = KIND_ERR;
                    bundle.err  = ERR_NO_QUOTE;
                    bundle.cnt  = 2'd1;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    phase_next = PH_STR;
                end
                else if (!(in_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}))
                begin
                    bundle.kind = KIND_ERR;
                    bundle.err  = ERR_NO_QUOTE;
                    bundle.cnt  = 2'd1;
                end
            end
            PH_STR:
            begin
                if (text_end)
                begin
                    bundle.kind = KIND_ERR;
                    bundle.err  = ERR_UNTERM;
                    bundle.cnt  = 2'd1;
                    phase_next  = PH_IDLE;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    bundle.kind = KIND_DONE;
                    bundle.cnt  = 2'd1;
                    phase_next  = PH_IDLE;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    bundle.bytes[0] = in_byte;
                    bundle.cnt      = 2'd1;
                end
            end
            PH_ESC:
            begin
                bundle.cnt = 2'd1;
                phase_next = PH_STR;
                if (text_end)
                begin
                    bundle.kind = KIND_ERR;
                    bundle.err  = ERR_END_ESC;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    case (in_byte)
                        CH_QUOTE:  bundle.bytes[0] = CH_QUOTE;
                        CH_BSLASH: bundle.bytes[0] = CH_BSLASH;
                        CH_SLASH:  bundle.bytes[0] = CH_SLASH;
                        ESC_B:     bundle.bytes[0] = CH_BS;
                        ESC_F:     bundle.bytes[0] = CH_FF;
                        ESC_N:     bundle.bytes[0] = CH_LF;
                        ESC_R:     bundle.bytes[0] = CH_CR;
                        ESC_T:     bundle.bytes[0] = CH_TAB;
                        ESC_U:
                        begin
                            bundle.cnt   = 2'd0;
                            phase_next   = PH_HEX;
                            hex_cnt_next = 2'd0;
                            cp_next      = 16'd0;
                        end
                        default:
                        begin
                            bundle.kind = KIND_ERR;
                            bundle.err  = ERR_UNKNOWN;
                            phase_next  = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_HEX:
            begin
                if (text_end || !is_hex)
                begin
                    bundle.kind  = KIND_ERR;
                    bundle.err   = text_end ? ERR_SHORT_U : ERR_BAD_HEX;
                    bundle.cnt   = 2'd1;
                    phase_next   = PH_IDLE;
                    hex_cnt_next = 2'd0;
                    cp_next      = 16'd0;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    // Fourth digit: emit the UTF-8 form of the code point.
                    if (cp_new < CP_2BYTE)
                    begin
                        bundle.bytes[0] = cp_new[7:0];
                        bundle.cnt      = 2'd1;
                    end
                    else if (cp_new < CP_3BYTE)
                    begin
                        bundle.bytes[0] = UTF8_LEAD2 | {3'd0, cp_new[10:6]};
                        bundle.bytes[1] = UTF8_CONT | {2'd0, cp_new[5:0]};
                        bundle.cnt      = 2'd2;
                    end
                    else
                    begin
                        bundle.bytes[0] = UTF8_LEAD3 | {4'd0, cp_new[15:12]};
                        bundle.bytes[1] = UTF8_CONT | {2'd0, cp_new[11:6]};
                        bundle.bytes[2] = UTF8_CONT | {2'd0, cp_new[5:0]};
                        bundle.cnt      = 2'd3;
                    end
                    phase_next   = PH_STR;
                    hex_cnt_next = 2'd0;
                    cp_next      = 16'd0;
                end
                else
                begin
                    cp_next      = cp_new;
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 16'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

>>> rtl/core/jsu_result_buf.sv
// Result register: holds one bundle and sends its results one per transfer.
// Depends on jsu_pkg, jsu_chan_if and the assertion macro header.
`include "json_string_unescaper_macros.svh"

module jsu_result_buf
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  bundle_t    bundle,
    output logic       free,
    jsu_chan_if.source result
);

    logic            valid_reg;
    logic [1:0]      idx_reg;
    logic [2:0][7:0] bytes_reg;
    logic [1:0]      kind_reg;
    logic [2:0]      err_reg;
    logic [1:0]      cnt_reg;

    logic            last;
    logic            fire;

    assign last = (idx_reg == cnt_reg - 2'd1);
    assign fire = valid_reg && result.ready;
    assign free = !valid_reg || (result.ready && last);

    assign result.valid               = valid_reg;
    assign result.payload.out_byte    = bytes_reg[idx_reg];
    assign result.payload.out_kind    = kind_reg;
    assign result.payload.error_code  = err_reg;
    assign result.payload.last_of_run = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (fire)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= bundle.bytes;
            kind_reg  <= bundle.kind;
            err_reg   <= bundle.err;
            cnt_reg   <= bundle.cnt;
        end
    end

    `JSU_ASSERT_IMPL(a_load_only_when_free, load, free && bundle.cnt != 2'd0, "bundle loaded over pending results")
    `JSU_ASSERT_IMPL(a_idx_in_range, valid_reg, idx_reg < cnt_reg, "result index beyond bundle count")
    `JSU_ASSERT_IMPL(a_single_non_byte, valid_reg && kind_reg != KIND_BYTE, cnt_reg == 2'd1, "done or error bundle holds more than one result")
    `JSU_ASSERT_NEXT(a_advance_in_run, fire && !last && !load, valid_reg && idx_reg == $past(idx_reg) + 2'd1, "run did not advance to next result")

endmodule

>>> rtl/core/json_string_unescaper.sv
// Top level of the JSON string unescaper: input register, decoder, result register.
// Depends on jsu_pkg, jsu_chan_if, jsu_decoder and jsu_result_buf.

// JSON string unescaper. Text bytes arrive on the text channel, one per
// transfer, with text_end marking the end of the text. Outside a string the
// block skips blanks and expects an opening quote; inside it passes bytes
// through, decodes the two-character escapes and turns \uXXXX into one to
// three UTF-8 bytes (surrogates are encoded singly, not paired). The closing
// quote yields a done result (out_kind 1); any error yields one error result
// (out_kind 2, error_code set) and returns the block to idle. last_of_run
// marks the final result caused by a text byte. Throughput: one text byte per
// cycle as long as each byte causes at most one result and result.ready is
// high; the last digit of a \u escape that encodes to two or three UTF-8
// bytes holds the result register until all its results have left, since
// results leave one per transfer. Bytes that cause no result (blanks, the
// opening quote, backslash, the u and first three \u digits) move on at once
// even while earlier results wait. Each text byte is registered in the input
// register; its results are then registered in the result register.
module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    jsu_chan_if.sink   text,
    jsu_chan_if.source result
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    bundle_t    bundle;
    logic       buf_free;
    logic       consume;
    logic       load;

    // The held byte moves on when its results fit in the result register,
    // or at once if it causes none.
    assign consume    = in_valid_reg && (bundle.cnt == 2'd0 || buf_free);
    assign load       = consume && bundle.cnt != 2'd0;
    assign text.ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.payload.in_byte;
            in_end_reg  <= text.payload.text_end;
        end
    end

    jsu_decoder u_decoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (consume),
        .in_byte  (in_byte_reg),
        .text_end (in_end_reg),
        .bundle   (bundle)
    );

    jsu_result_buf u_result_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .bundle (bundle),
        .free   (buf_free),
        .result (result)
    );

endmodule
